[rtl/kri_pkg.sv]
`timescale 1ns / 1ps
package kri_pkg;
   localparam int MAX_PARTS_DEF   = 16;
   localparam int MAX_KEYS_DEF    = 16;
   localparam int MAX_MOTIONS_DEF = 8;
   localparam int NUM_PARTS_W     = 5;
   localparam int ANGLE_W         = 16;
   localparam int DIVIDEND_W      = 17;
   localparam int FRAME_W         = 8;

   localparam logic signed [17:0] ANGLE_HALF = 18'sd12861;
   localparam logic signed [17:0] ANGLE_FULL = 18'sd25723;
   localparam logic signed [17:0] ANGLE_MAX  = 18'sd32767;
   localparam logic signed [17:0] ANGLE_MIN  = -18'sd32768;

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_ROT  = 2'd1,
      CMD_FRM  = 2'd2,
      CMD_HDR  = 2'd3
   } cmd_type;

   typedef logic [2:0][ANGLE_W-1:0] rot_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [2:0]         motion;
      logic [3:0]         key_index;
      logic [3:0]         part_index;
      logic signed [15:0] rot_x;
      logic signed [15:0] rot_y;
      logic signed [15:0] rot_z;
      logic [7:0]         frame_count;
      logic [4:0]         key_count;
      logic               loop_flag;
   } req_type;

   typedef struct packed {
      logic [3:0]         out_part;
      logic signed [15:0] out_rot_x;
      logic signed [15:0] out_rot_y;
      logic signed [15:0] out_rot_z;
      logic [4:0]         out_key;
      logic               last_part;
   } rsp_type;

   function automatic logic [ANGLE_W-1:0] wrap_angle(input logic signed [17:0] v);
      logic signed [17:0] w;
      w = v;
      if (w > ANGLE_HALF) begin
         w = w - ANGLE_FULL;
      end else if (w < -ANGLE_HALF) begin
         w = w + ANGLE_FULL;
      end
      if (w > ANGLE_MAX) begin
         w = ANGLE_MAX;
      end else if (w < ANGLE_MIN) begin
         w = ANGLE_MIN;
      end
      return w[ANGLE_W-1:0];
   endfunction
endpackage

[rtl/kri_ram.sv]
`timescale 1ns / 1ps
module kri_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/kri_div.sv]
`timescale 1ns / 1ps
module kri_div (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    go,
   input  logic signed [kri_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [kri_pkg::FRAME_W-1:0]             divisor,
   output logic                                    done,
   output logic signed [kri_pkg::DIVIDEND_W-1:0]   quotient
);
   import kri_pkg::*;

   localparam int MAG_W = DIVIDEND_W - 1;
   localparam int CNT_W = $clog2(MAG_W + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [FRAME_W-1:0]   rem_ff, rem_in;
   logic [MAG_W-1:0]     quo_ff, quo_in;
   logic [FRAME_W-1:0]   den_ff, den_in;
   logic                 neg_ff, neg_in;
   logic [FRAME_W:0]     trial;
   logic [DIVIDEND_W-1:0] mag;

   always_comb begin
      mag     = dividend[DIVIDEND_W-1] ? (~dividend + 1'b1) : dividend;
      trial   = {rem_ff, quo_ff[MAG_W-1]} - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = mag[MAG_W-1:0];
         den_in  = divisor;
         neg_in  = dividend[DIVIDEND_W-1];
      end else if (busy_ff) begin
         if (trial[FRAME_W]) begin
            rem_in = {rem_ff[FRAME_W-2:0], quo_ff[MAG_W-1]};
            quo_in = {quo_ff[MAG_W-2:0], 1'b0};
         end else begin
            rem_in = trial[FRAME_W-1:0];
            quo_in = {quo_ff[MAG_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
endmodule

[rtl/keyframe_rotation_interpolator_unit.sv]
`timescale 1ns / 1ps
// Write requests are taken in idle. A tick first (re)starts a motion where needed, loading key 0 for
// every part, then interpolates the P parts (per part one key read and three serial divides,
// one quotient bit a cycle), then returns one result per part.
// One request at a time; ready returns while the last result may still wait.
// Synchronous reset clears motion, counters and rotations and sets num_parts to 1;
// key tables and motion headers hold no reset value until written.
module keyframe_rotation_interpolator_unit #(
   parameter int MAX_PARTS   = kri_pkg::MAX_PARTS_DEF,
   parameter int MAX_KEYS    = kri_pkg::MAX_KEYS_DEF,
   parameter int MAX_MOTIONS = kri_pkg::MAX_MOTIONS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  kri_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output kri_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [kri_pkg::NUM_PARTS_W-1:0]  csr_data
);
   import kri_pkg::*;

   localparam int MW  = MAX_MOTIONS > 1 ? $clog2(MAX_MOTIONS) : 1;
   localparam int KW  = MAX_KEYS > 1 ? $clog2(MAX_KEYS) : 1;
   localparam int PW  = MAX_PARTS > 1 ? $clog2(MAX_PARTS) : 1;
   localparam int PCW = $clog2(MAX_PARTS + 1);
   localparam int KCW = $clog2(MAX_KEYS + 1);
   localparam int RAW = MW + KW + PW;
   localparam int FAW = MW + KW;

   typedef enum logic [3:0] {
      S_IDLE, S_START_RD, S_START_WR, S_ADV, S_FRM, S_ROT_RD, S_DIV_GO, S_DIV_WAIT, S_EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic [2:0]             cur_ff, cur_in;
   logic [2:0]             sm_ff, sm_in;
   logic                   emit_after_ff, emit_after_in;
   logic [KCW-1:0]         key_ff, key_in;
   logic [FRAME_W-1:0]     frm_ff, frm_in;
   logic [PCW-1:0]         p_ff, p_in;
   logic [1:0]             ax_ff, ax_in;
   logic [NUM_PARTS_W-1:0] nparts_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   rot_type                part_rot_ff [MAX_PARTS];
   rot_type                seg_rot_ff  [MAX_PARTS];
   logic [5:0]             hdr_ff      [MAX_MOTIONS];

   logic                   krd_en, frd_en, rot_we, frm_we, hdr_we;
   logic [RAW-1:0]         krd_addr, kwr_addr;
   logic [FAW-1:0]         frd_addr, fwr_addr;
   rot_type                krd_data, kwr_data;
   logic [FRAME_W-1:0]     frd_data;
   logic                   start_we, ax_we, seg_copy, div_go, div_done;
   logic signed [DIVIDEND_W-1:0] dividend, quotient;

   logic [5:0]             npw, hkw;
   logic [PCW-1:0]         np;
   logic [KCW-1:0]         nk, tgt;
   logic [5:0]             hdr_cur;
   logic [2:0]             tm;
   logic [PW-1:0]          pi;
   logic [ANGLE_W-1:0]     new_angle;
   logic                   in_range;

   assign npw      = (6'(nparts_ff) > 6'(MAX_PARTS)) ? 6'(MAX_PARTS) : 6'(nparts_ff);
   assign np       = PCW'(npw);
   assign hdr_cur  = hdr_ff[MW'(cur_ff)];
   assign hkw      = {1'b0, hdr_cur[4:0]};
   assign nk       = (hkw > 6'(MAX_KEYS)) ? KCW'(MAX_KEYS) : KCW'(hkw);
   assign tgt      = (key_ff == nk - 1'b1) ? '0 : key_ff + 1'b1;
   assign tm       = (32'(req_data.motion) >= MAX_MOTIONS) ? 3'd0 : req_data.motion;
   assign pi       = PW'(p_ff);
   assign kwr_addr = {MW'(req_data.motion), KW'(req_data.key_index), PW'(req_data.part_index)};
   assign kwr_data = {req_data.rot_z, req_data.rot_y, req_data.rot_x};
   assign fwr_addr = {MW'(req_data.motion), KW'(req_data.key_index)};
   assign dividend = $signed({krd_data[ax_ff][ANGLE_W-1], krd_data[ax_ff]})
                   - $signed({seg_rot_ff[pi][ax_ff][ANGLE_W-1], seg_rot_ff[pi][ax_ff]});
   assign new_angle = wrap_angle(18'($signed(part_rot_ff[pi][ax_ff])) + 18'(quotient));
   assign in_range = (32'(req_data.motion) < MAX_MOTIONS)
                  && (32'(req_data.key_index) < MAX_KEYS);

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      sm_in         = sm_ff;
      emit_after_in = emit_after_ff;
      key_in        = key_ff;
      frm_in        = frm_ff;
      p_in          = p_ff;
      ax_in         = ax_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      krd_en        = 1'b0;
      krd_addr      = {MW'(cur_ff), KW'(tgt), pi};
      frd_en        = 1'b0;
      frd_addr      = {MW'(cur_ff), KW'(key_ff)};
      rot_we        = 1'b0;
      frm_we        = 1'b0;
      hdr_we        = 1'b0;
      start_we      = 1'b0;
      ax_we         = 1'b0;
      seg_copy      = 1'b0;
      div_go        = 1'b0;
      req_ready     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_data.command)
                  CMD_ROT: begin
                     rot_we = in_range && (32'(req_data.part_index) < MAX_PARTS);
                  end
                  CMD_FRM: begin
                     frm_we = in_range;
                  end
                  CMD_HDR: begin
                     hdr_we = 32'(req_data.motion) < MAX_MOTIONS;
                  end
                  CMD_TICK: begin
                     if (np != '0) begin
                        p_in = '0;
                        sm_in = tm;
                        emit_after_in = 1'b0;
                        state_in = (tm != cur_ff) ? S_START_RD : S_ADV;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_START_RD: begin
            krd_en   = 1'b1;
            krd_addr = {MW'(sm_ff), KW'(0), pi};
            state_in = S_START_WR;
         end
         S_START_WR: begin
            start_we = 1'b1;
            p_in     = p_ff + 1'b1;
            state_in = S_START_RD;
            if (p_ff + 1'b1 == np) begin
               cur_in   = sm_ff;
               key_in   = '0;
               frm_in   = '0;
               p_in     = '0;
               state_in = emit_after_ff ? S_EMIT : S_ADV;
            end
         end
         S_ADV: begin
            if (key_ff < nk) begin
               frd_en   = 1'b1;
               state_in = S_FRM;
            end else if (!hdr_cur[5]) begin
               sm_in         = '0;
               emit_after_in = 1'b1;
               p_in          = '0;
               state_in      = S_START_RD;
            end else begin
               key_in   = '0;
               frm_in   = '0;
               p_in     = '0;
               state_in = S_EMIT;
            end
         end
         S_FRM: begin
            p_in = '0;
            if (frm_ff < frd_data) begin
               state_in = S_ROT_RD;
            end else begin
               key_in   = key_ff + 1'b1;
               frm_in   = '0;
               seg_copy = 1'b1;
               state_in = S_EMIT;
            end
         end
         S_ROT_RD: begin
            krd_en   = 1'b1;
            ax_in    = '0;
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            div_go   = 1'b1;
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               ax_we = 1'b1;
               if (ax_ff == 2'd2) begin
                  p_in     = p_ff + 1'b1;
                  state_in = S_ROT_RD;
                  if (p_ff + 1'b1 == np) begin
                     frm_in   = frm_ff + 1'b1;
                     p_in     = '0;
                     state_in = S_EMIT;
                  end
               end else begin
                  ax_in    = ax_ff + 1'b1;
                  state_in = S_DIV_GO;
               end
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_in.out_part  = 4'(p_ff);
               rsp_in.out_rot_x = part_rot_ff[pi][0];
               rsp_in.out_rot_y = part_rot_ff[pi][1];
               rsp_in.out_rot_z = part_rot_ff[pi][2];
               rsp_in.out_key   = 5'(key_ff);
               rsp_in.last_part = (p_ff + 1'b1 == np);
               p_in             = p_ff + 1'b1;
               if (p_ff + 1'b1 == np) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cur_ff        <= '0;
         sm_ff         <= '0;
         emit_after_ff <= 1'b0;
         key_ff        <= '0;
         frm_ff        <= '0;
         p_ff          <= '0;
         ax_ff         <= '0;
         nparts_ff     <= NUM_PARTS_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_ff        <= cur_in;
         sm_ff         <= sm_in;
         emit_after_ff <= emit_after_in;
         key_ff        <= key_in;
         frm_ff        <= frm_in;
         p_ff          <= p_in;
         ax_ff         <= ax_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) begin
            nparts_ff <= csr_data;
         end
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PARTS; i++) begin
            part_rot_ff[i] <= '0;
            seg_rot_ff[i]  <= '0;
         end
      end else if (seg_copy) begin
         for (int i = 0; i < MAX_PARTS; i++) begin
            if (PCW'(i) < np) begin
               seg_rot_ff[i] <= part_rot_ff[i];
            end
         end
      end else if (start_we) begin
         part_rot_ff[pi] <= krd_data;
         seg_rot_ff[pi]  <= krd_data;
      end else if (ax_we) begin
         part_rot_ff[pi][ax_ff] <= new_angle;
      end
   end

   always_ff @(posedge clock) begin
      if (hdr_we) begin
         hdr_ff[MW'(req_data.motion)] <= {req_data.loop_flag, req_data.key_count};
      end
   end

   kri_ram #(.WIDTH(3 * ANGLE_W), .DEPTH(2 ** RAW)) u_key_ram (
      .clock   (clock),
      .wr_en   (rot_we),
      .wr_addr (kwr_addr),
      .wr_data (kwr_data),
      .rd_en   (krd_en),
      .rd_addr (krd_addr),
      .rd_data (krd_data)
   );

   kri_ram #(.WIDTH(FRAME_W), .DEPTH(2 ** FAW)) u_frame_ram (
      .clock   (clock),
      .wr_en   (frm_we),
      .wr_addr (fwr_addr),
      .wr_data (req_data.frame_count),
      .rd_en   (frd_en),
      .rd_addr (frd_addr),
      .rd_data (frd_data)
   );

   kri_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (dividend),
      .divisor  (frd_data),
      .done     (div_done),
      .quotient (quotient)
   );

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
   import kri_pkg::*;

   localparam int DRAIN_CYCLES = 1500;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [NUM_PARTS_W-1:0] csr_data = '0;

   keyframe_rotation_interpolator_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // animation state mirror
   int  key_rot [8][16][16][3];
   bit  key_rot_set [8][16][16];
   int  key_frames [8][16];
   bit  key_frames_set [8][16];
   int  motion_hdr [8];
   bit  motion_hdr_set [8];
   int  pose [16][3];
   int  seg_start [16][3];
   int  cur_motion, key_cnt, frame_cnt, parts_reg;
   rsp_type pending_poses[$];

   bit  failed;
   int  burst_left;
   bit  no_gaps;
   int  hold_cycles;

   function automatic int wrap_rot(int v);
      if (v > 12861) v -= 25723;
      else if (v < -12861) v += 25723;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   function automatic int active_parts();
      return parts_reg > 16 ? 16 : parts_reg;
   endfunction

   function automatic int keys_in(int m);
      int n;
      n = motion_hdr[m] & 31;
      return n > 16 ? 16 : n;
   endfunction

   function automatic void load_motion(int m);
      cur_motion = m;
      key_cnt = 0;
      frame_cnt = 0;
      for (int p = 0; p < active_parts(); p++) begin
         for (int a = 0; a < 3; a++) begin
            pose[p][a] = key_rot[m][0][p][a];
            seg_start[p][a] = key_rot[m][0][p][a];
         end
      end
   endfunction

   function automatic void step_frame();
      int m, nk, f, tgt;
      m = cur_motion;
      nk = keys_in(m);
      if (key_cnt < nk) begin
         f = key_frames[m][key_cnt];
         if (frame_cnt < f) begin
            tgt = (key_cnt == nk - 1) ? 0 : key_cnt + 1;
            for (int p = 0; p < active_parts(); p++)
               for (int a = 0; a < 3; a++)
                  pose[p][a] = wrap_rot(pose[p][a]
                     + (key_rot[m][tgt][p][a] - seg_start[p][a]) / f);
            frame_cnt++;
         end else begin
            key_cnt++;
            frame_cnt = 0;
            for (int p = 0; p < active_parts(); p++)
               seg_start[p] = pose[p];
         end
      end else if (motion_hdr[m][5] == 1'b0) begin
         load_motion(0);
      end else begin
         key_cnt = 0;
         frame_cnt = 0;
      end
   endfunction

   function automatic void model_request(req_type r);
      rsp_type o;
      int np;
      case (cmd_type'(r.command))
         CMD_ROT: begin
            key_rot[r.motion][r.key_index][r.part_index][0] = int'(r.rot_x);
            key_rot[r.motion][r.key_index][r.part_index][1] = int'(r.rot_y);
            key_rot[r.motion][r.key_index][r.part_index][2] = int'(r.rot_z);
            key_rot_set[r.motion][r.key_index][r.part_index] = 1;
         end
         CMD_FRM: begin
            key_frames[r.motion][r.key_index] = int'(r.frame_count);
            key_frames_set[r.motion][r.key_index] = 1;
         end
         CMD_HDR: begin
            motion_hdr[r.motion] = int'({r.loop_flag, r.key_count});
            motion_hdr_set[r.motion] = 1;
         end
         default: begin
            np = active_parts();
            if (np != 0) begin
               if (int'(r.motion) != cur_motion) load_motion(int'(r.motion));
               step_frame();
               for (int i = 0; i < np; i++) begin
                  o.out_part  = i[3:0];
                  o.out_rot_x = pose[i][0][15:0];
                  o.out_rot_y = pose[i][1][15:0];
                  o.out_rot_z = pose[i][2][15:0];
                  o.out_key   = key_cnt[4:0];
                  o.last_part = (i == np - 1);
                  pending_poses.push_back(o);
               end
            end
         end
      endcase
   endfunction

   // every table entry a tick on this motion could read has been written
   function automatic bit motion_loaded(int m);
      int nk;
      if (!motion_hdr_set[m]) return 0;
      nk = keys_in(m);
      for (int k = 0; k < nk; k++)
         if (!key_frames_set[m][k]) return 0;
      for (int k = 0; k < (nk > 0 ? nk : 1); k++)
         for (int p = 0; p < active_parts(); p++)
            if (!key_rot_set[m][k][p]) return 0;
      return 1;
   endfunction

   function automatic req_type noise_req(cmd_type c);
      req_type r;
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      r = raw[$bits(req_type)-1:0];
      r.command = c;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_poses.size() == 0) begin
            $display("%0t: unexpected result %p", $time, rsp_data);
            failed = 1;
         end else begin
            e = pending_poses.pop_front();
            if (rsp_data.out_part !== e.out_part || rsp_data.out_rot_x !== e.out_rot_x ||
                rsp_data.out_rot_y !== e.out_rot_y || rsp_data.out_rot_z !== e.out_rot_z ||
                rsp_data.out_key !== e.out_key || rsp_data.last_part !== e.last_part) begin
               $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
               failed = 1;
            end
         end
      end
   end

   // receiver stall pattern, with an optional long hold-off
   initial begin
      int phase_cnt;
      int mode;
      phase_cnt = 0;
      mode = 0;
      forever begin
         @(posedge clock);
         phase_cnt++;
         if (phase_cnt % 300 == 0) mode = $urandom_range(0, 2);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (mode == 0) rsp_ready <= 1'b1;
         else if (mode == 1) rsp_ready <= ($urandom_range(0, 1) == 1);
         else rsp_ready <= ($urandom_range(0, 7) != 0);
      end
   end

   task automatic push_req(input req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      model_request(r);
      if (burst_left == 0 && !no_gaps) begin
         req_valid <= 1'b0;
         burst_left = $urandom_range(0, 12);
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end else if (burst_left > 0) begin
         burst_left--;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_poses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_parts(input int v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v[NUM_PARTS_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      parts_reg = v;
      @(posedge clock);
   endtask

   task automatic write_key(int m, int k, int p, int x, int y, int z);
      req_type r;
      r = noise_req(CMD_ROT);
      r.motion = m[2:0]; r.key_index = k[3:0]; r.part_index = p[3:0];
      r.rot_x = x[15:0]; r.rot_y = y[15:0]; r.rot_z = z[15:0];
      push_req(r);
   endtask

   task automatic write_frames(int m, int k, int f);
      req_type r;
      r = noise_req(CMD_FRM);
      r.motion = m[2:0]; r.key_index = k[3:0]; r.frame_count = f[7:0];
      push_req(r);
   endtask

   task automatic write_header(int m, int nk, int lp);
      req_type r;
      r = noise_req(CMD_HDR);
      r.motion = m[2:0]; r.key_count = nk[4:0]; r.loop_flag = lp[0];
      push_req(r);
   endtask

   task automatic tick(int m);
      req_type r;
      r = noise_req(CMD_TICK);
      r.motion = m[2:0];
      if (motion_loaded(m) && motion_loaded(0)) push_req(r);
   endtask

   // header, frame counts and key rotations for all active parts
   task automatic load_random_motion(int m, int nk_field, int max_frames);
      int nk;
      nk = nk_field > 16 ? 16 : nk_field;
      write_header(m, nk_field, $urandom_range(0, 1));
      for (int k = 0; k < nk; k++)
         write_frames(m, k, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, max_frames));
      for (int k = 0; k < (nk > 0 ? nk : 1); k++)
         for (int p = 0; p < active_parts(); p++)
            write_key(m, k, p, $urandom, $urandom, $urandom);
   endtask

   task automatic test_directed();
      write_header(0, 2, 1);
      write_frames(0, 0, 0);
      write_frames(0, 1, 3);
      write_key(0, 0, 0, 32767, -32768, 0);
      write_key(0, 1, 0, -32768, 32767, 12862);
      repeat (6) tick(0);
      write_header(1, 1, 0);
      write_frames(1, 0, 255);
      write_key(1, 0, 0, -12862, 12861, -1);
      repeat (3) tick(1);
      write_frames(1, 0, 2);
      write_header(2, 0, 0);
      write_key(2, 0, 0, 100, -100, 4095);
      tick(2);
      tick(1);
      tick(1);
      tick(1);
      tick(1);
      tick(1);
   endtask

   task automatic test_long_motion();
      load_random_motion(3, 31, 2);
      repeat (40) tick(3);
   endtask

   task automatic test_part_counts();
      int settings [6] = '{1, 16, 3, 31, 0, 5};
      int m;
      foreach (settings[i]) begin
         set_parts(settings[i]);
         if (!motion_loaded(0)) load_random_motion(0, $urandom_range(1, 2), 3);
         repeat (1) begin
            m = $urandom_range(0, 7);
            load_random_motion(m, active_parts() > 4 ? $urandom_range(1, 2)
                                                     : $urandom_range(0, 4), 4);
         end
         repeat (active_parts() > 4 ? 8 : 20) begin
            if ($urandom_range(0, 9) == 0)
               push_req(noise_req(cmd_type'($urandom_range(1, 3))));
            else
               tick($urandom_range(0, 9) < 7 ? cur_motion : $urandom_range(0, 7));
         end
      end
   endtask

   task automatic test_backpressure();
      set_parts(16);
      if (!motion_loaded(0)) load_random_motion(0, 1, 3);
      req_valid <= 1'b0;
      @(posedge clock);
      hold_cycles = 3000;
      no_gaps = 1;
      repeat (4) tick(0);
      no_gaps = 0;
   endtask

   initial begin
      #4000000;
      $display("keyframe_rotation_interpolator_unit test failed");
      $finish;
   end

   initial begin
      parts_reg = 1;
      cur_motion = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_long_motion();
      test_part_counts();
      test_backpressure();
      set_parts(2);
      drain();
      if (!failed) begin
         $display("keyframe_rotation_interpolator_unit test passed");
      end else begin
         $display("keyframe_rotation_interpolator_unit test failed");
      end
      $finish;
   end
endmodule

[sim.f]
rtl/kri_pkg.sv
rtl/kri_ram.sv
rtl/kri_div.sv
rtl/keyframe_rotation_interpolator_unit.sv
test/tb_top.sv
